/* rtl/core/scbp_pkg.sv */
// Shared constants, codes and types of the size-class buffer pool.
package scbp_pkg;

    // Table geometry
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int IDX_W   = $clog2(SLOTS + 1);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Field widths
    localparam int CLS_W   = 5;
    localparam int ID_W    = 32;
    localparam int BYTES_W = 32;
    localparam int MIN_W   = 5;
    localparam int IDLE_W  = 8;
    localparam int ENTRY_W = CLS_W + ID_W;

    // Largest size class
    localparam logic [CLS_W-1:0] CLS_MAX = 5'd31;

    // Configuration reset values
    localparam logic [MIN_W-1:0]  MIN_RESET      = 5'd12;
    localparam logic [IDLE_W-1:0] MAX_IDLE_RESET = 8'd2;

    // Configuration register indexes
    localparam logic REG_MIN_BUCKET = 1'b0;
    localparam logic REG_MAX_IDLE   = 1'b1;

    // Operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_NEW      = 3'd1,
        ST_REG_FAIL = 3'd2,
        ST_FULL     = 3'd3,
        ST_KEPT     = 3'd4,
        ST_EVICTED  = 3'd5,
        ST_IGNORED  = 3'd6
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_CLASS     = 3'd1,
        S_REL_LATCH = 3'd2,
        S_SCAN      = 3'd3,
        S_DONE      = 3'd4
    } state_t;

endpackage

/* rtl/core/size_class_buffer_pool.sv */
// Top level of the size-class buffer pool: sequencer, slot flags and config port.
//
// Usage: pulse start with the request fields while busy is low; the word is
// taken at that edge. An acquire (operation 0) rounds request_bytes up to a
// power-of-two class no smaller than 2^min_bucket_log2 and grants an idle
// slot, registers one, or makes a new slot. A release (operation 1) frees
// release_slot and evicts it when more than max_idle_per_bucket idle slots
// share its class. Each word yields exactly one result word: done is high
// for one cycle with status, slot, bucket_log2, buffer_id and registered.
// The receiver cannot stall; done drops after that cycle but the fields hold.
// An acquire holds busy through its class steps (one bit per cycle, from
// min_bucket_log2 up, at most 31 - min) and the slot scan; a grant at slot
// j ends the scan there. A release holds busy through the latch state and a
// full slot scan; a release of an empty slot leaves busy low. done is high in
// the first cycle after the word with busy low. The slot scan reads one
// class/id entry per cycle from the slot RAM through one compare unit.
// Reset clears all slot flags and the id counter and loads
// min_bucket_log2 = 12, max_idle_per_bucket = 2; no clearing pass is needed.
// Configuration must be written over the APB port only while busy is low;
// the block itself does not enforce it.
module size_class_buffer_pool (
    input  logic                        clk,
    input  logic                        rst_n,
    // Request side
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [scbp_pkg::BYTES_W-1:0] request_bytes,
    input  logic                        need_registration,
    input  logic                        registration_ok,
    input  logic [3:0]                  release_slot,
    // Result side
    output logic                        done,
    output logic [2:0]                  status,
    output logic [3:0]                  slot,
    output logic [scbp_pkg::CLS_W-1:0]  bucket_log2,
    output logic [scbp_pkg::ID_W-1:0]   buffer_id,
    output logic                        registered,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import scbp_pkg::*;

    // Sequencer
    state_t state_reg, state_next;

    // Item registers
    logic                op_reg, op_next;
    logic                need_reg, need_next;
    logic                regok_reg, regok_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [CLS_W-1:0]    lg_reg, lg_next;
    logic [SLOT_W-1:0]   k_reg, k_next;

    // Scan registers
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic                cand_vld_reg, cand_vld_next;
    logic [SLOT_W-1:0]   cand_idx_reg, cand_idx_next;
    logic [CLS_W-1:0]    cand_cls_reg, cand_cls_next;
    logic [ID_W-1:0]     cand_id_reg, cand_id_next;
    logic                empty_vld_reg, empty_vld_next;
    logic [SLOT_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Pool state
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    busyf_reg, busyf_next;
    logic [SLOTS-1:0]    regf_reg, regf_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;

    // Configuration
    logic [MIN_W-1:0]    min_reg;
    logic [IDLE_W-1:0]   max_idle_reg;

    // Result registers
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [3:0]          slot_reg, slot_next;
    logic [CLS_W-1:0]    bucket_reg, bucket_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                registered_reg, registered_next;

    // Slot RAM ports
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Compare unit and scan decode
    logic                accept;
    logic                cfg_write;
    logic [CLS_W-1:0]    rd_cls;
    logic [ID_W-1:0]     rd_id;
    logic                issue;
    logic                eval;
    logic                p_idle;
    logic                fit;
    logic                hit_now;
    logic                match;
    logic                last;
    logic                scan_exit;
    logic                grow;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign rd_cls    = ram_rdata[ENTRY_W-1:ID_W];
    assign rd_id     = ram_rdata[ID_W-1:0];

    // Slot class/id store
    scbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read the released slot at accept, then walk the table
    assign ram_raddr = (state_reg == S_IDLE) ? release_slot[SLOT_W-1:0]
                                             : idx_reg[SLOT_W-1:0];

    // Evaluate the slot whose entry just came out of the RAM
    assign issue     = (state_reg == S_SCAN) && (idx_reg < IDX_W'(SLOTS));
    assign eval      = (state_reg == S_SCAN) && pend_reg;
    assign p_idle    = valid_reg[pend_idx_reg] && !busyf_reg[pend_idx_reg];
    assign fit       = eval && (op_reg == OP_ACQUIRE) && p_idle && (rd_cls >= lg_reg);
    assign hit_now   = fit && (!need_reg || regf_reg[pend_idx_reg]);
    assign match     = eval && (op_reg == OP_RELEASE) && p_idle
                       && (rd_cls == cand_cls_reg);
    assign last      = eval && (pend_idx_reg == SLOT_W'(SLOTS - 1));
    assign scan_exit = hit_now || last;

    // Class step: grow while 2^lg is below the byte count
    assign grow = (state_reg == S_CLASS) && (lg_reg != CLS_MAX)
                  && ((ID_W'(1) << lg_reg) < bytes_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_RELEASE)
                    begin
                        if (valid_reg[release_slot[SLOT_W-1:0]])
                        begin
                            state_next = S_REL_LATCH;
                        end
                    end
                    else
                    begin
                        state_next = S_CLASS;
                    end
                end
            end
            S_CLASS:
            begin
                if (!grow)
                begin
                    state_next = S_SCAN;
                end
            end
            S_REL_LATCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_exit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        op_next         = op_reg;
        need_next       = need_reg;
        regok_next      = regok_reg;
        bytes_next      = bytes_reg;
        lg_next         = lg_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        cand_vld_next   = cand_vld_reg;
        cand_idx_next   = cand_idx_reg;
        cand_cls_next   = cand_cls_reg;
        cand_id_next    = cand_id_reg;
        empty_vld_next  = empty_vld_reg;
        empty_idx_next  = empty_idx_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        busyf_next      = busyf_reg;
        regf_next       = regf_reg;
        next_id_next    = next_id_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        slot_next       = slot_reg;
        bucket_next     = bucket_reg;
        id_next         = id_reg;
        registered_next = registered_reg;
        ram_we          = 1'b0;
        ram_waddr       = empty_idx_reg;
        ram_wdata       = {lg_reg, next_id_reg};

        case (state_reg)
            S_IDLE:
            begin
                // Take the request word and clear the scan record
                if (accept)
                begin
                    op_next        = operation;
                    need_next      = need_registration;
                    regok_next     = registration_ok;
                    bytes_next     = request_bytes;
                    lg_next        = min_reg;
                    k_next         = release_slot[SLOT_W-1:0];
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    hit_next       = 1'b0;
                    cand_vld_next  = 1'b0;
                    empty_vld_next = 1'b0;
                    cnt_next       = '0;
                    if (operation == OP_RELEASE)
                    begin
                        if (valid_reg[release_slot[SLOT_W-1:0]])
                        begin
                            // Free the slot before counting idle peers
                            busyf_next[release_slot[SLOT_W-1:0]] = 1'b0;
                        end
                        else
                        begin
                            // Drop a release of an empty slot
                            done_next       = 1'b1;
                            status_next     = ST_IGNORED;
                            slot_next       = release_slot;
                            bucket_next     = '0;
                            id_next         = '0;
                            registered_next = 1'b0;
                        end
                    end
                end
            end
            S_CLASS:
            begin
                // Advance the class one step
                if (grow)
                begin
                    lg_next = lg_reg + CLS_W'(1);
                end
            end
            S_REL_LATCH:
            begin
                // Hold class and id of the released slot
                cand_cls_next = rd_cls;
                cand_id_next  = rd_id;
            end
            S_SCAN:
            begin
                // Issue the next read
                pend_next     = issue;
                pend_idx_next = idx_reg[SLOT_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                // First empty entry
                if (eval && !valid_reg[pend_idx_reg] && !empty_vld_reg)
                begin
                    empty_vld_next = 1'b1;
                    empty_idx_next = pend_idx_reg;
                end
                // Last fitting idle slot, or the granted one
                if (fit)
                begin
                    cand_vld_next = 1'b1;
                    cand_idx_next = pend_idx_reg;
                    cand_cls_next = rd_cls;
                    cand_id_next  = rd_id;
                end
                if (hit_now)
                begin
                    hit_next = 1'b1;
                end
                // Count idle slots of the released class
                if (match)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                if (op_reg == OP_RELEASE)
                begin
                    slot_next   = 4'(k_reg);
                    bucket_next = cand_cls_reg;
                    if (32'(cnt_reg) > 32'(max_idle_reg))
                    begin
                        // Evict the released slot
                        status_next     = ST_EVICTED;
                        id_next         = cand_id_reg;
                        registered_next = regf_reg[k_reg];
                        valid_next[k_reg] = 1'b0;
                        busyf_next[k_reg] = 1'b0;
                        regf_next[k_reg]  = 1'b0;
                    end
                    else
                    begin
                        status_next     = ST_KEPT;
                        id_next         = '0;
                        registered_next = 1'b0;
                    end
                end
                else if (hit_reg)
                begin
                    // Grant an idle slot as it is
                    status_next     = ST_REUSED;
                    slot_next       = 4'(cand_idx_reg);
                    bucket_next     = cand_cls_reg;
                    id_next         = cand_id_reg;
                    registered_next = regf_reg[cand_idx_reg];
                    busyf_next[cand_idx_reg] = 1'b1;
                end
                else if (cand_vld_reg)
                begin
                    // Register the last fitting slot
                    slot_next   = 4'(cand_idx_reg);
                    bucket_next = cand_cls_reg;
                    id_next     = cand_id_reg;
                    if (regok_reg)
                    begin
                        status_next     = ST_REUSED;
                        registered_next = 1'b1;
                        regf_next[cand_idx_reg]  = 1'b1;
                        busyf_next[cand_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        status_next     = ST_REG_FAIL;
                        registered_next = 1'b0;
                    end
                end
                else if (!empty_vld_reg)
                begin
                    // Flag a full table
                    status_next     = ST_FULL;
                    slot_next       = '0;
                    bucket_next     = lg_reg;
                    id_next         = '0;
                    registered_next = 1'b0;
                end
                else
                begin
                    // Make a new slot, consuming an id either way
                    next_id_next = next_id_reg + ID_W'(1);
                    slot_next    = 4'(empty_idx_reg);
                    bucket_next  = lg_reg;
                    id_next      = next_id_reg;
                    if (need_reg && !regok_reg)
                    begin
                        status_next     = ST_REG_FAIL;
                        registered_next = 1'b0;
                    end
                    else
                    begin
                        status_next     = ST_NEW;
                        registered_next = need_reg;
                        valid_next[empty_idx_reg] = 1'b1;
                        busyf_next[empty_idx_reg] = 1'b1;
                        regf_next[empty_idx_reg]  = need_reg;
                        ram_we = 1'b1;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            busyf_reg    <= '0;
            regf_reg     <= '0;
            next_id_reg  <= '0;
            done_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            cand_vld_reg <= 1'b0;
            empty_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            min_reg      <= MIN_RESET;
            max_idle_reg <= MAX_IDLE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            busyf_reg     <= busyf_next;
            regf_reg      <= regf_next;
            next_id_reg   <= next_id_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            cand_vld_reg  <= cand_vld_next;
            empty_vld_reg <= empty_vld_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            // Write configuration
            if (cfg_write)
            begin
                if (paddr[2] == REG_MIN_BUCKET)
                begin
                    min_reg <= pwdata[MIN_W-1:0];
                end
                else
                begin
                    max_idle_reg <= pwdata[IDLE_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        regok_reg      <= regok_next;
        bytes_reg      <= bytes_next;
        lg_reg         <= lg_next;
        k_reg          <= k_next;
        pend_idx_reg   <= pend_idx_next;
        cand_idx_reg   <= cand_idx_next;
        cand_cls_reg   <= cand_cls_next;
        cand_id_reg    <= cand_id_next;
        empty_idx_reg  <= empty_idx_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        bucket_reg     <= bucket_next;
        id_reg         <= id_next;
        registered_reg <= registered_next;
    end

    // Register read-back
    always_comb
    begin
        if (paddr[2] == REG_MIN_BUCKET)
        begin
            prdata = {{(32 - MIN_W){1'b0}}, min_reg};
        end
        else
        begin
            prdata = {{(32 - IDLE_W){1'b0}}, max_idle_reg};
        end
    end

    assign pready      = 1'b1;
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign bucket_log2 = bucket_reg;
    assign buffer_id   = id_reg;
    assign registered  = registered_reg;

endmodule

/* rtl/core/scbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module scbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
